// ===== design/ghm_pkg.sv =====
package ghm_pkg;

    // Default table sizes
    localparam int DEF_BUCKETS = 256;
    localparam int DEF_ENTRIES = 256;

    // Request and result field widths
    localparam int CODE_W   = 21;
    localparam int TYPE_W   = 3;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 5;

    // Hash: 32-bit product of the key and the FNV prime
    localparam int              PROD_W    = 32;
    localparam logic [PROD_W-1:0] HASH_MUL = 32'd16777619;

    // Highest valid font type
    localparam logic [TYPE_W-1:0] TYPE_MAX = 3'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    // Glyph width for a valid font type
    function automatic logic [SIZE_W-1:0] size_w(input logic [KIND_W-1:0] kind);
        logic [SIZE_W-1:0] w;
        case (kind)
            2'd1:    w = 5'd6;
            2'd2:    w = 5'd8;
            2'd3:    w = 5'd16;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

    // Glyph height for a valid font type
    function automatic logic [SIZE_W-1:0] size_h(input logic [KIND_W-1:0] kind);
        logic [SIZE_W-1:0] h;
        case (kind)
            2'd1:    h = 5'd8;
            2'd2:    h = 5'd16;
            2'd3:    h = 5'd16;
            default: h = 5'd0;
        endcase
        return h;
    endfunction

endpackage

// ===== design/glyph_hash_map_top.sv =====
// Glyph map keyed on (character code, font type), chained hash table.
// Request: drive i_mode (0 lookup, 1 insert), i_char_code, i_font_type and
// i_glyph_address with start high; the request is taken at a clock edge where
// busy is low. Busy stays high until the result has been issued.
// Result: o_status, o_found_address, o_glyph_width and o_glyph_height are
// valid for exactly one cycle while o_valid is high; the receiver cannot
// stall, so each result must be captured in that cycle.
// Flow: a font type above 3 answers in the next cycle and busy stays low.
// Otherwise the states S_MOD and S_REM reduce the hash modulo BUCKETS by
// reciprocal multiplication, S_HEAD reads the bucket head memory, and the
// chain entries are then read one after another on the single entry memory
// read port until a match or the chain end. The next request is taken in the
// cycle the result is shown.
// Reset: after i_rst_n is released the bucket heads are cleared one per cycle,
// with busy high; the entry pool count restarts at zero.
module glyph_hash_map_top #(
    parameter int BUCKETS = ghm_pkg::DEF_BUCKETS,
    parameter int ENTRIES = ghm_pkg::DEF_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [ghm_pkg::CODE_W-1:0]     i_char_code,
    input  logic [ghm_pkg::TYPE_W-1:0]     i_font_type,
    input  logic [ghm_pkg::ADDR_W-1:0]     i_glyph_address,
    output logic                           o_valid,
    output logic [ghm_pkg::STATUS_W-1:0]   o_status,
    output logic [ghm_pkg::ADDR_W-1:0]     o_found_address,
    output logic [ghm_pkg::SIZE_W-1:0]     o_glyph_width,
    output logic [ghm_pkg::SIZE_W-1:0]     o_glyph_height
);
    import ghm_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);

    // Exact quotient of a 32-bit value by BUCKETS: (x * RECIP) >> RSH
    localparam int RSH = PROD_W + $clog2(BUCKETS);
    localparam logic [PROD_W:0] RECIP =
        (PROD_W+1)'(((64'd1 << RSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_REM   = 7'b0001000,
        S_HEAD  = 7'b0010000,
        S_HCHK  = 7'b0100000,
        S_ECHK  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] glyph;
        logic [LW-1:0]     link;
    } t_entry;

    // Memories: chain heads (link = slot + 1, zero is empty) and entry pool
    logic [LW-1:0] mem_head [BUCKETS];
    t_entry        mem_entry [ENTRIES];

    t_state              r_state, n_state;
    logic                r_mode, n_mode;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [PROD_W-1:0]   r_quo, n_quo;
    logic [BW-1:0]       r_rem, n_rem;
    logic [LW-1:0]       r_used, n_used;
    logic [BW-1:0]       r_clr, n_clr;
    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [ADDR_W-1:0]   r_o_found, n_o_found;
    logic [SIZE_W-1:0]   r_o_w, n_o_w;
    logic [SIZE_W-1:0]   r_o_h, n_o_h;

    logic [LW-1:0] r_head_rd;
    t_entry        r_ent_rd;

    logic          head_rd_en;
    logic          head_wr_en;
    logic [BW-1:0] head_wr_addr;
    logic [LW-1:0] head_wr_data;
    logic          ent_rd_en;
    logic [IW-1:0] ent_rd_addr;
    logic          ent_wr_en;
    t_entry        ent_wr_data;

    logic          do_finish;
    logic          hit;
    logic [ADDR_W-1:0] hit_glyph;
    logic          ent_match;
    logic [LW-1:0] link_m1;
    logic [CODE_W-1:0] key;
    logic [2*PROD_W:0] recip_prod;
    logic [PROD_W-1:0] rem_full;

    assign key       = i_char_code ^ CODE_W'(i_font_type);
    assign ent_match = (r_ent_rd.code == r_code) && (r_ent_rd.kind == r_kind);

    // Hash reduction: quotient estimate, then remainder
    assign recip_prod = (2*PROD_W+1)'(r_prod) * (2*PROD_W+1)'(RECIP);
    assign rem_full   = r_prod - r_quo * PROD_W'(BUCKETS);

    // Control and datapath next state
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_code     = r_code;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_prod     = r_prod;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_used     = r_used;
        n_clr      = r_clr;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_w      = r_o_w;
        n_o_h      = r_o_h;

        head_rd_en   = 1'b0;
        head_wr_en   = 1'b0;
        head_wr_addr = r_rem;
        head_wr_data = LW'(r_used + 1'b1);
        ent_rd_en    = 1'b0;
        ent_rd_addr  = '0;
        ent_wr_en    = 1'b0;
        ent_wr_data  = '{code: r_code, kind: r_kind, glyph: r_addr, link: r_head_rd};
        do_finish    = 1'b0;
        hit          = 1'b0;
        hit_glyph    = r_ent_rd.glyph;
        link_m1      = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the bucket heads to empty
                head_wr_en   = 1'b1;
                head_wr_addr = r_clr;
                head_wr_data = '0;
                n_clr        = BW'(r_clr + 1'b1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_mode = i_mode;
                    n_code = i_char_code;
                    n_kind = i_font_type[KIND_W-1:0];
                    n_addr = i_glyph_address;
                    n_prod = PROD_W'({{(PROD_W-CODE_W){1'b0}}, key} * HASH_MUL);
                    n_rem  = '0;
                    if (i_font_type > TYPE_MAX) begin
                        // Reject at once, no state touched
                        n_o_valid  = 1'b1;
                        n_o_status = ST_INVALID;
                        n_o_found  = '0;
                        n_o_w      = '0;
                        n_o_h      = '0;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // Take the quotient of the product by BUCKETS
                n_quo   = PROD_W'(recip_prod >> RSH);
                n_state = S_REM;
            end
            S_REM: begin
                // Keep the remainder as the bucket index
                n_rem   = rem_full[BW-1:0];
                n_state = S_HEAD;
            end
            S_HEAD: begin
                head_rd_en = 1'b1;
                n_state    = S_HCHK;
            end
            S_HCHK: begin
                // Empty bucket ends the walk, else fetch the head entry
                if (r_head_rd == '0) begin
                    do_finish = 1'b1;
                end else begin
                    link_m1     = LW'(r_head_rd - 1'b1);
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = link_m1[IW-1:0];
                    n_state     = S_ECHK;
                end
            end
            S_ECHK: begin
                // Compare the fetched entry, then advance along the chain
                if (ent_match) begin
                    do_finish = 1'b1;
                    hit       = 1'b1;
                end else if (r_ent_rd.link == '0) begin
                    do_finish = 1'b1;
                end else begin
                    link_m1     = LW'(r_ent_rd.link - 1'b1);
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = link_m1[IW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Issue the result and link a new entry on an insert miss with room left
        if (do_finish) begin
            n_state   = S_IDLE;
            n_o_valid = 1'b1;
            n_o_w     = size_w(r_kind);
            n_o_h     = size_h(r_kind);
            n_o_found = '0;
            if (hit) begin
                n_o_status = r_mode ? ST_DUP : ST_OK;
                n_o_found  = hit_glyph;
            end else if (!r_mode) begin
                n_o_status = ST_MISS;
            end else if (r_used == LW'(ENTRIES)) begin
                n_o_status = ST_FULL;
            end else begin
                n_o_status = ST_OK;
                ent_wr_en  = 1'b1;
                head_wr_en = 1'b1;
                n_used     = LW'(r_used + 1'b1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_used    <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_code     <= n_code;
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_prod     <= n_prod;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_w      <= n_o_w;
        r_o_h      <= n_o_h;
    end

    // Bucket head memory
    always_ff @(posedge i_clk) begin
        if (head_wr_en) begin
            mem_head[head_wr_addr] <= head_wr_data;
        end
        if (head_rd_en) begin
            r_head_rd <= mem_head[r_rem];
        end
    end

    // Entry pool memory
    always_ff @(posedge i_clk) begin
        if (ent_wr_en) begin
            mem_entry[r_used[IW-1:0]] <= ent_wr_data;
        end
        if (ent_rd_en) begin
            r_ent_rd <= mem_entry[ent_rd_addr];
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found_address = r_o_found;
    assign o_glyph_width   = r_o_w;
    assign o_glyph_height  = r_o_h;

endmodule

// ===== test/ghm_tb_pkg.sv =====
package ghm_tb_pkg;

    // Request kinds
    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } mode_e;

    // Font types; anything above ghm_pkg::TYPE_MAX is invalid
    localparam logic [ghm_pkg::TYPE_W-1:0] FONT_NONE      = 3'd0;
    localparam logic [ghm_pkg::TYPE_W-1:0] FONT_ASCII_6X8  = 3'd1;
    localparam logic [ghm_pkg::TYPE_W-1:0] FONT_ASCII_8X16 = 3'd2;
    localparam logic [ghm_pkg::TYPE_W-1:0] FONT_CHINESE    = 3'd3;
    localparam logic [ghm_pkg::TYPE_W-1:0] FONT_LAST       = 3'd7;

endpackage

// ===== test/glyph_map_checker.sv =====
module glyph_map_checker #(
    parameter int BUCKETS = ghm_pkg::DEF_BUCKETS,
    parameter int ENTRIES = ghm_pkg::DEF_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_mode,
    input  logic [ghm_pkg::CODE_W-1:0]     i_char_code,
    input  logic [ghm_pkg::TYPE_W-1:0]     i_font_type,
    input  logic [ghm_pkg::ADDR_W-1:0]     i_glyph_address,
    input  logic                           i_valid,
    input  logic [ghm_pkg::STATUS_W-1:0]   i_status,
    input  logic [ghm_pkg::ADDR_W-1:0]     i_found_address,
    input  logic [ghm_pkg::SIZE_W-1:0]     i_glyph_width,
    input  logic [ghm_pkg::SIZE_W-1:0]     i_glyph_height,
    output int                             o_error_count,
    output int                             o_pending
);
    import ghm_pkg::*;
    import ghm_tb_pkg::*;

    // Links hold slot index + 1, zero marks the end of a chain
    localparam int LINK_W = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   found;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
    } glyph_result_t;

    // Shadow copy of the table
    logic [LINK_W-1:0] head_link  [BUCKETS];
    logic [CODE_W-1:0] slot_code  [ENTRIES];
    logic [KIND_W-1:0] slot_kind  [ENTRIES];
    logic [ADDR_W-1:0] slot_glyph [ENTRIES];
    logic [LINK_W-1:0] slot_next  [ENTRIES];
    int                slots_used;

    glyph_result_t     pending_results [$];
    int                result_index;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        result_index  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t result %0d: %s", $time, result_index, what);
        o_error_count++;
    endtask

    // FNV prime multiply in 32 bits, then reduce to a bucket
    function automatic int bucket_index(input logic [CODE_W-1:0] code,
                                        input logic [TYPE_W-1:0] ftype);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(code ^ CODE_W'(ftype));
        prod = prod * HASH_MUL;
        return int'(prod % BUCKETS);
    endfunction

    // Walk a chain from its head; return slot + 1 of the match or zero
    function automatic int find_slot(input int bucket,
                                     input logic [CODE_W-1:0] code,
                                     input logic [KIND_W-1:0] kind);
        int link;
        int steps;
        link  = head_link[bucket];
        steps = 0;
        while (link != 0 && steps < ENTRIES) begin
            if (slot_code[link-1] == code && slot_kind[link-1] == kind)
                return link;
            link = slot_next[link-1];
            steps++;
        end
        return 0;
    endfunction

    // Compute the answer to one request and update the shadow table
    function automatic glyph_result_t predict_glyph_result(
        input logic              mode,
        input logic [CODE_W-1:0] code,
        input logic [TYPE_W-1:0] ftype,
        input logic [ADDR_W-1:0] addr
    );
        glyph_result_t     r;
        logic [KIND_W-1:0] kind;
        int                bucket;
        int                hit;
        r = '0;
        if (ftype > TYPE_MAX) begin
            r.status = ST_INVALID;
            return r;
        end
        kind = ftype[KIND_W-1:0];
        case (ftype)
            FONT_ASCII_6X8: begin
                r.width  = 5'd6;
                r.height = 5'd8;
            end
            FONT_ASCII_8X16: begin
                r.width  = 5'd8;
                r.height = 5'd16;
            end
            FONT_CHINESE: begin
                r.width  = 5'd16;
                r.height = 5'd16;
            end
            default: begin
                r.width  = 5'd0;
                r.height = 5'd0;
            end
        endcase
        bucket = bucket_index(code, ftype);
        hit    = find_slot(bucket, code, kind);
        if (mode == MODE_LOOKUP) begin
            if (hit != 0) begin
                r.status = ST_OK;
                r.found  = slot_glyph[hit-1];
            end else begin
                r.status = ST_MISS;
            end
        end else if (hit != 0) begin
            r.status = ST_DUP;
            r.found  = slot_glyph[hit-1];
        end else if (slots_used >= ENTRIES) begin
            r.status = ST_FULL;
        end else begin
            // link the new slot at the chain head
            slot_code[slots_used]  = code;
            slot_kind[slots_used]  = kind;
            slot_glyph[slots_used] = addr;
            slot_next[slots_used]  = head_link[bucket];
            head_link[bucket]      = LINK_W'(slots_used + 1);
            slots_used++;
            r.status = ST_OK;
        end
        return r;
    endfunction

    // Check results against the oldest expectation, then record new requests
    always @(posedge i_clk) begin : watch_channels
        glyph_result_t want;
        if (!i_rst_n) begin
            for (int b = 0; b < BUCKETS; b++)
                head_link[b] = '0;
            slots_used = 0;
            pending_results.delete();
        end else begin
            if (i_valid !== 1'b0) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, status %0d",
                                              i_status));
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_status, want.status));
                    if (i_found_address !== want.found)
                        report_mismatch($sformatf("found_address %h, want %h",
                                                  i_found_address, want.found));
                    if (i_glyph_width !== want.width)
                        report_mismatch($sformatf("glyph_width %0d, want %0d",
                                                  i_glyph_width, want.width));
                    if (i_glyph_height !== want.height)
                        report_mismatch($sformatf("glyph_height %0d, want %0d",
                                                  i_glyph_height, want.height));
                end
                result_index++;
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                pending_results.push_back(predict_glyph_result(i_mode, i_char_code,
                                                               i_font_type, i_glyph_address));
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import ghm_pkg::*;
    import ghm_tb_pkg::*;

    localparam int BUCKETS      = DEF_BUCKETS;
    localparam int ENTRIES      = DEF_ENTRIES;
    localparam int RANDOM_ITEMS = 1900;
    // Clearing pass plus a full chain walk plus the longest sender gap, with margin
    localparam int IDLE_LIMIT   = 4 * (BUCKETS + ENTRIES + 40);
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CODE_W-1:0] CODE_TOP = 21'h10FFFF;
    // With 256 buckets the bucket follows the low byte of code xor type,
    // so codes sharing these low bytes pile up into long chains
    localparam logic [7:0] HOT_LOW [4] = '{8'h00, 8'h3C, 8'hC3, 8'hFF};

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [TYPE_W-1:0] ftype;
    } glyph_key_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_mode;
    logic [CODE_W-1:0]   i_char_code;
    logic [TYPE_W-1:0]   i_font_type;
    logic [ADDR_W-1:0]   i_glyph_address;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_found_address;
    logic [SIZE_W-1:0]   o_glyph_width;
    logic [SIZE_W-1:0]   o_glyph_height;

    int                  error_count;
    int                  pending;
    int                  idle_cycles = 0;
    int                  burst_left  = 0;
    glyph_key_t          used_keys [$];

    glyph_hash_map_top #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_font_type     (i_font_type),
        .i_glyph_address (i_glyph_address),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_found_address (o_found_address),
        .o_glyph_width   (o_glyph_width),
        .o_glyph_height  (o_glyph_height)
    );

    glyph_map_checker #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) map_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_font_type     (i_font_type),
        .i_glyph_address (i_glyph_address),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_found_address (o_found_address),
        .i_glyph_width   (o_glyph_width),
        .i_glyph_height  (o_glyph_height),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    // Clock, period 20
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one request and hold it until taken; start stays high on return
    task automatic send_request(input mode_e mode,
                                input logic [CODE_W-1:0] code,
                                input logic [TYPE_W-1:0] ftype,
                                input logic [ADDR_W-1:0] addr);
        i_mode          <= mode;
        i_char_code     <= code;
        i_font_type     <= ftype;
        i_glyph_address <= addr;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Insert and remember the key for later hits and duplicates
    task automatic insert_key(input logic [CODE_W-1:0] code,
                              input logic [TYPE_W-1:0] ftype,
                              input logic [ADDR_W-1:0] addr);
        glyph_key_t key;
        key.code  = code;
        key.ftype = ftype;
        used_keys.push_back(key);
        send_request(MODE_INSERT, code, ftype, addr);
    endtask

    // Count down the burst; at its end maybe drop start for a random gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // One random request: mostly well-formed traffic, much of it on known keys
    task automatic send_random_item();
        int         pick;
        glyph_key_t key;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 30 || used_keys.size() == 0) begin
            // fresh key, half of them aimed at crowded buckets
            if ($urandom_range(0, 1))
                code = CODE_W'(($urandom_range(0, CODE_TOP >> 8) << 8) |
                               HOT_LOW[2'($urandom_range(0, 3))]);
            else
                code = CODE_W'($urandom_range(0, CODE_TOP));
            insert_key(code, TYPE_W'($urandom_range(0, TYPE_MAX)),
                       ADDR_W'($urandom_range(0, 16'hFFFF)));
        end else if (pick < 75 && pick >= 65) begin
            // random key, mostly a miss
            send_request(MODE_LOOKUP, CODE_W'($urandom_range(0, CODE_TOP)),
                         TYPE_W'($urandom_range(0, TYPE_MAX)),
                         ADDR_W'($urandom_range(0, 16'hFFFF)));
        end else if (pick >= 75 && pick < 87) begin
            // invalid font type
            send_request(mode_e'($urandom_range(0, 1)), CODE_W'($urandom_range(0, CODE_TOP)),
                         TYPE_W'($urandom_range(TYPE_MAX + 1, FONT_LAST)),
                         ADDR_W'($urandom_range(0, 16'hFFFF)));
        end else begin
            key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            if (pick < 55) begin
                send_request(MODE_LOOKUP, key.code, key.ftype,
                             ADDR_W'($urandom_range(0, 16'hFFFF)));
            end else if (pick < 65) begin
                send_request(MODE_INSERT, key.code, key.ftype,
                             ADDR_W'($urandom_range(0, 16'hFFFF)));
            end else begin
                // same code under another type is another key
                key.ftype = TYPE_W'((key.ftype + $urandom_range(1, TYPE_MAX)) %
                                    (TYPE_MAX + 1));
                send_request(MODE_LOOKUP, key.code, key.ftype,
                             ADDR_W'($urandom_range(0, 16'hFFFF)));
            end
        end
        pace_sender();
    endtask

    initial begin
        start           <= 1'b0;
        i_mode          <= MODE_LOOKUP;
        i_char_code     <= '0;
        i_font_type     <= FONT_NONE;
        i_glyph_address <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes of code, type and address
        send_request(MODE_LOOKUP, '0, FONT_NONE, '0);
        insert_key('0, FONT_NONE, 16'h0000);
        insert_key(CODE_TOP, FONT_CHINESE, 16'hFFFF);
        insert_key(21'h0FFFFF, FONT_ASCII_6X8, 16'h5A5A);
        insert_key(21'h0FFFFF, FONT_ASCII_8X16, 16'hA5A5);
        send_request(MODE_LOOKUP, '0, FONT_NONE, 16'hFFFF);
        send_request(MODE_LOOKUP, CODE_TOP, FONT_CHINESE, '0);
        pace_sender();
        send_request(MODE_LOOKUP, 21'h0FFFFF, FONT_ASCII_6X8, '0);
        send_request(MODE_LOOKUP, 21'h0FFFFF, FONT_ASCII_8X16, '0);
        send_request(MODE_LOOKUP, 21'h0FFFFF, FONT_CHINESE, '0);
        // duplicate keeps the first address
        send_request(MODE_INSERT, CODE_TOP, FONT_CHINESE, 16'h1234);
        pace_sender();
        // invalid types leave the table alone
        send_request(MODE_LOOKUP, CODE_TOP, TYPE_W'(TYPE_MAX + 1), '0);
        send_request(MODE_INSERT, CODE_TOP, FONT_LAST, 16'hFFFF);
        send_request(MODE_INSERT, '0, 3'd5, 16'h0F0F);
        send_request(MODE_LOOKUP, '0, 3'd5, '0);
        pace_sender();
        // grow one chain behind code 0, then hit its tail and miss past it
        insert_key(21'h000100, FONT_NONE, 16'h0100);
        insert_key(21'h000201, FONT_ASCII_6X8, 16'h0201);
        insert_key(21'h000302, FONT_ASCII_8X16, 16'h0302);
        insert_key(21'h000403, FONT_CHINESE, 16'h0403);
        send_request(MODE_LOOKUP, '0, FONT_NONE, '0);
        send_request(MODE_LOOKUP, 21'h000500, FONT_NONE, '0);
        send_request(MODE_INSERT, 21'h000100, FONT_NONE, 16'h9999);
        send_request(MODE_LOOKUP, 21'h000201, FONT_ASCII_8X16, '0);
        pace_sender();

        repeat (RANDOM_ITEMS) send_random_item();

        // drain outstanding results, then a short quiet tail
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ghm_pkg.sv
design/glyph_hash_map_top.sv
test/ghm_tb_pkg.sv
test/glyph_map_checker.sv
test/tb_top.sv
